/* src/assert_macros.svh */
// assertion macros used by the top level of the traffic light controller
// active in simulation only, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* src/tlco_pkg.sv */
// shared types, codes and constants of the traffic light controller
// no dependencies
`default_nettype none

package tlco_pkg;

    // phase state, one-hot, doubles as the lamp pattern
    typedef enum logic [2:0] {
        PH_HORIZ = 3'b001,
        PH_AMBER = 3'b010,
        PH_VERT  = 3'b100
    } t_phase;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TPS   = 2'd0,
        CFG_GO    = 2'd1,
        CFG_AMBER = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] TPS_RESET   = 8'd100;
    localparam logic [6:0] GO_RESET    = 7'd10;
    localparam logic [6:0] AMBER_RESET = 7'd5;
    localparam logic [6:0] SEC_MAX     = 7'd99;

    // switch patterns with exactly one switch pulled low
    localparam logic [2:0] SW_HORIZ = 3'b110;
    localparam logic [2:0] SW_AMBER = 3'b101;
    localparam logic [2:0] SW_VERT  = 3'b011;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [6:0] go_seconds;
        logic [6:0] amber_seconds;
    } t_cfg;

    typedef struct packed {
        logic [2:0] lamps;
        logic [6:0] seconds_left;
        logic       overridden;
    } t_view;

    // seven-segment code of one decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hFC;
            4'd1:    code = 8'h60;
            4'd2:    code = 8'hDA;
            4'd3:    code = 8'hF2;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'hB6;
            4'd6:    code = 8'hBE;
            4'd7:    code = 8'hE0;
            4'd8:    code = 8'hFE;
            4'd9:    code = 8'hF6;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* src/tlco_cfg.sv */
// configuration registers of the traffic light controller
// depends on tlco_pkg
`default_nettype none

module tlco_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    output tlco_pkg::t_cfg     o_cfg
);
    import tlco_pkg::*;

    t_cfg       r_cfg;
    logic [6:0] w_secs;

    // phase times take the low seven data bits and saturate at 99
    assign w_secs = (i_cfg_data[6:0] > SEC_MAX) ? SEC_MAX : i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= TPS_RESET;
            r_cfg.go_seconds       <= GO_RESET;
            r_cfg.amber_seconds    <= AMBER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TPS:   r_cfg.ticks_per_second <= i_cfg_data;
                CFG_GO:    r_cfg.go_seconds       <= w_secs;
                CFG_AMBER: r_cfg.amber_seconds    <= w_secs;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/tlco_step.sv */
// phase sequencer, override and countdown state of the traffic light controller
// depends on tlco_pkg
`default_nettype none

module tlco_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_tick,
    input  wire logic [2:0]    i_sw_n,
    input  wire tlco_pkg::t_cfg i_cfg,
    output tlco_pkg::t_view    o_view
);
    import tlco_pkg::*;

    t_phase     r_phase, n_phase;
    t_phase     r_after, n_after;
    t_phase     r_saved_phase, n_saved_phase;
    t_phase     r_saved_after, n_saved_after;
    logic [2:0] r_forced, n_forced;
    logic [6:0] r_count, n_count;
    logic [7:0] r_presc, n_presc;

    logic [2:0] w_req;
    logic [8:0] w_presc_inc;

    always_comb begin
        case (i_sw_n)
            SW_HORIZ: w_req = PH_HORIZ;
            SW_AMBER: w_req = PH_AMBER;
            SW_VERT:  w_req = PH_VERT;
            default:  w_req = 3'b000;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_after       = r_after;
        n_saved_phase = r_saved_phase;
        n_saved_after = r_saved_after;
        n_forced      = r_forced;
        n_count       = r_count;
        n_presc       = r_presc;

        // switches first
        if (w_req != 3'b000) begin
            if (r_forced == 3'b000) begin
                n_saved_phase = r_phase;
                n_saved_after = r_after;
            end
            n_forced = w_req;
        end else if (r_forced != 3'b000) begin
            n_forced = 3'b000;
            n_phase  = r_saved_phase;
            n_after  = r_saved_after;
            n_presc  = 8'd0;
        end

        // then timing
        w_presc_inc = {1'b0, n_presc} + 9'd1;
        if (n_forced == 3'b000 && i_tick) begin
            if (w_presc_inc >= {1'b0, i_cfg.ticks_per_second}) begin
                n_presc = 8'd0;
                if (r_count == 7'd0) begin
                    unique case (n_phase)
                        PH_HORIZ: begin
                            n_after = PH_VERT;
                            n_phase = PH_AMBER;
                            n_count = i_cfg.amber_seconds;
                        end
                        PH_VERT: begin
                            n_after = PH_HORIZ;
                            n_phase = PH_AMBER;
                            n_count = i_cfg.amber_seconds;
                        end
                        default: begin
                            n_phase = n_after;
                            n_count = i_cfg.go_seconds;
                        end
                    endcase
                end else begin
                    n_count = r_count - 7'd1;
                end
            end else begin
                n_presc = w_presc_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HORIZ;
            r_after       <= PH_VERT;
            r_saved_phase <= PH_HORIZ;
            r_saved_after <= PH_VERT;
            r_forced      <= 3'b000;
            r_count       <= GO_RESET;
            r_presc       <= 8'd0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_after       <= n_after;
            r_saved_phase <= n_saved_phase;
            r_saved_after <= n_saved_after;
            r_forced      <= n_forced;
            r_count       <= n_count;
            r_presc       <= n_presc;
        end
    end

    assign o_view.lamps        = (n_forced != 3'b000) ? n_forced : n_phase;
    assign o_view.seconds_left = n_count;
    assign o_view.overridden   = (n_forced != 3'b000);

endmodule

`default_nettype wire

/* src/tlco_disp.sv */
// two-digit seven-segment decoder for the countdown display
// depends on tlco_pkg
`default_nettype none

module tlco_disp (
    input  wire logic [6:0] i_secs,
    output logic      [7:0] o_tens_seg,
    output logic      [7:0] o_ones_seg
);
    import tlco_pkg::*;

    logic [14:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [6:0]  w_ones;

    // divide by ten via reciprocal, exact for values up to 159
    assign w_prod     = {8'd0, i_secs} * 15'd205;
    assign w_tens     = w_prod[14:11];
    assign w_tens_x10 = {w_tens, 3'b000} + {2'b00, w_tens, 1'b0};
    assign w_ones     = i_secs - w_tens_x10;

    assign o_tens_seg = seg_code(w_tens);
    assign o_ones_seg = seg_code(w_ones[3:0]);

endmodule

`default_nettype wire

/* src/traffic_light_controller_with_override.sv */
// top level of the traffic light controller with switch override
// depends on tlco_pkg, tlco_cfg, tlco_step, tlco_disp and assert_macros.svh
//
//   channel   valid          stall          payload
//   input     i_in_valid     o_in_stall     i_base_tick, i_switches_n
//   result    o_out_valid    i_out_stall    o_lamps, o_seconds_left, o_tens_segments,
//                                           o_ones_segments, o_overridden
//   config    i_cfg_we       (none)         i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the result is not stalled
// the item sits in the input register, the state update runs when it moves to the
// result register, which needs that register empty or being taken that same cycle
// a stalled result holds; the input register still takes one more item behind it
// synchronous active-low reset: phase horizontal go, countdown 10, no override,
// configuration 100 ticks, 10 go seconds, 5 amber seconds
`default_nettype none
`include "assert_macros.svh"

module traffic_light_controller_with_override (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input item channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_base_tick,
    input  wire logic [2:0] i_switches_n,
    // result item channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [2:0] o_lamps,
    output logic      [6:0] o_seconds_left,
    output logic      [7:0] o_tens_segments,
    output logic      [7:0] o_ones_segments,
    output logic            o_overridden,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import tlco_pkg::*;

    // input register
    logic       r_in_valid;
    logic       r_in_tick;
    logic [2:0] r_in_sw_n;

    // result register
    logic       r_out_valid;
    t_view      r_out_view;
    logic [7:0] r_out_tens;
    logic [7:0] r_out_ones;

    logic       w_out_free;   // result register can take a new item
    logic       w_advance;    // item moves from input to result register
    logic       w_in_accept;
    t_cfg       w_cfg;
    t_view      w_view;
    logic [7:0] w_tens_seg;
    logic [7:0] w_ones_seg;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    tlco_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // state commits only when the item leaves the input register
    tlco_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_tick  (r_in_tick),
        .i_sw_n  (r_in_sw_n),
        .i_cfg   (w_cfg),
        .o_view  (w_view)
    );

    tlco_disp u_disp (
        .i_secs     (w_view.seconds_left),
        .o_tens_seg (w_tens_seg),
        .o_ones_seg (w_ones_seg)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_tick <= i_base_tick;
            r_in_sw_n <= i_switches_n;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_view <= w_view;
            r_out_tens <= w_tens_seg;
            r_out_ones <= w_ones_seg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lamps         = r_out_view.lamps;
    assign o_seconds_left  = r_out_view.seconds_left;
    assign o_tens_segments = r_out_tens;
    assign o_ones_segments = r_out_ones;
    assign o_overridden    = r_out_view.overridden;

    // every result shows exactly one lamp group
    `ASSERT_PROP(a_lamps_onehot, i_clk, i_rst_n, o_out_valid |-> $onehot(o_lamps), "lamps not one-hot")

    // countdown never leaves the two-digit range
    `ASSERT_NEVER(a_secs_range, i_clk, i_rst_n, o_out_valid && (o_seconds_left > SEC_MAX), "countdown above 99")

    // a held item in the input register is never dropped
    `ASSERT_PROP(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_advance) |=> r_in_valid, "held item lost")

endmodule

`default_nettype wire
